// ----- sv/assert_macros.svh -----
// Assertion macros used by the record lock table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RLT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record lock table assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record lock table assertion failed");

`endif

// ----- sv/rlt_pkg.sv -----
// Types, codes and constants shared by the record lock table modules.
`default_nettype none

package rlt_pkg;

    localparam int RLT_ENTRIES     = 64;
    localparam int RLT_KEY_BITS    = 16;
    localparam int RLT_OWNER_BITS  = 8;

    localparam int RLT_KEY_FIELD_W   = 16;
    localparam int RLT_OWNER_FIELD_W = 8;
    localparam int RLT_RANGE_W       = 31;

    localparam logic [RLT_RANGE_W-1:0] RLT_RANGE_MAX = '1;

    // Command codes.
    localparam logic [1:0] CMD_SET     = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    // Lock type codes.
    localparam logic [1:0] LOCK_READ   = 2'd0;
    localparam logic [1:0] LOCK_WRITE  = 2'd1;
    localparam logic [1:0] LOCK_UNLOCK = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_WOULD_BLOCK = 2'd1;
    localparam logic [1:0] STAT_NO_SPACE    = 2'd2;

    // Held type codes.
    localparam logic [1:0] HELD_READ  = 2'd0;
    localparam logic [1:0] HELD_WRITE = 2'd1;
    localparam logic [1:0] HELD_NONE  = 2'd2;

    typedef struct packed {
        logic [1:0]                   command;
        logic [RLT_KEY_FIELD_W-1:0]   file_key;
        logic [RLT_OWNER_FIELD_W-1:0] owner_id;
        logic [1:0]                   lock_type;
        logic [RLT_RANGE_W-1:0]       range_start;
        logic [RLT_RANGE_W-1:0]       range_len;
    } rlt_req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [1:0]             held_kind;
        logic [RLT_RANGE_W-1:0] held_start;
        logic [RLT_RANGE_W-1:0] held_len;
    } rlt_rsp_t;

    // What a pass along the chain does in each cell.
    typedef enum logic [1:0] {
        MODE_SCAN    = 2'd0,
        MODE_PLACE   = 2'd1,
        MODE_UNLOCK  = 2'd2,
        MODE_RELEASE = 2'd3
    } rlt_mode_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_LAUNCH = 2'd1,
        S_RUN    = 2'd2,
        S_DONE   = 2'd3
    } rlt_state_t;

    // Request fields seen by every cell while a pass runs.
    typedef struct packed {
        rlt_mode_t              mode;
        logic                   req_write;
        logic [RLT_RANGE_W-1:0] start;
        logic [RLT_RANGE_W-1:0] len;
        logic [RLT_RANGE_W-1:0] rng_end;
    } rlt_bcast_t;

    // Record handed from one cell to the next along with the pass token.
    typedef struct packed {
        logic                   token;
        logic                   found;
        logic                   placed;
        logic                   hit_write;
        logic [RLT_RANGE_W-1:0] hit_start;
        logic [RLT_RANGE_W-1:0] hit_len;
    } rlt_carry_t;

endpackage

`default_nettype wire

// ----- sv/rlt_cell.sv -----
// One lock slot of the chain: holds its entry and updates it when the pass token arrives.
`default_nettype none

module rlt_cell
    import rlt_pkg::*;
#(
    parameter int KEY_W   = RLT_KEY_BITS,
    parameter int OWNER_W = RLT_OWNER_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic [OWNER_W-1:0] owner,
    input  wire rlt_bcast_t         bcast,
    input  wire rlt_carry_t         carry_in,
    output rlt_carry_t              carry_out
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [KEY_W-1:0]       key_reg;
    logic [OWNER_W-1:0]     owner_reg;
    logic                   write_reg;
    logic [RLT_RANGE_W-1:0] start_reg;
    logic [RLT_RANGE_W-1:0] len_reg;
    logic [RLT_RANGE_W-1:0] end_reg;
    rlt_carry_t             carry_reg;
    rlt_carry_t             carry_next;

    logic owner_eq;
    logic key_eq;
    logic ovl;
    logic conflict;
    logic drop;
    logic place;

    assign owner_eq = (owner_reg == owner);
    assign key_eq   = (key_reg == key);
    assign ovl      = (start_reg < bcast.rng_end) && (bcast.start < end_reg);
    assign conflict = valid_reg && !owner_eq && key_eq && ovl
                      && (bcast.req_write || write_reg);
    assign drop     = valid_reg && owner_eq && key_eq && ovl;

    always_comb
    begin
        carry_next = carry_in;
        valid_next = valid_reg;
        place      = 1'b0;
        if (carry_in.token)
        begin
            unique case (bcast.mode)
                MODE_SCAN:
                begin
                    if (conflict && !carry_in.found)
                    begin
                        carry_next.found     = 1'b1;
                        carry_next.hit_write = write_reg;
                        carry_next.hit_start = start_reg;
                        carry_next.hit_len   = len_reg;
                    end
                end
                MODE_PLACE:
                begin
                    // The owner's overlapping lock is dropped first, so its slot may be reused.
                    if (drop)
                    begin
                        valid_next = 1'b0;
                    end
                    if ((!valid_reg || drop) && !carry_in.placed)
                    begin
                        place             = 1'b1;
                        valid_next        = 1'b1;
                        carry_next.placed = 1'b1;
                    end
                end
                MODE_UNLOCK:
                begin
                    if (drop)
                    begin
                        valid_next = 1'b0;
                    end
                end
                MODE_RELEASE:
                begin
                    if (valid_reg && owner_eq)
                    begin
                        valid_next = 1'b0;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (place)
        begin
            key_reg   <= key;
            owner_reg <= owner;
            write_reg <= bcast.req_write;
            start_reg <= bcast.start;
            len_reg   <= bcast.len;
            end_reg   <= bcast.rng_end;
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

// ----- sv/rlt_ctrl.sv -----
// Command sequencer: takes an item, runs passes along the cell chain (none for a no-op) and builds the result.
`default_nettype none

`include "assert_macros.svh"

module rlt_ctrl
    import rlt_pkg::*;
#(
    parameter int KEY_W   = RLT_KEY_BITS,
    parameter int OWNER_W = RLT_OWNER_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rlt_req_t           request,
    output logic                    done,
    output rlt_rsp_t                result,
    output logic [KEY_W-1:0]        key,
    output logic [OWNER_W-1:0]      owner,
    output rlt_bcast_t              bcast,
    output logic                    inject,
    input  wire rlt_carry_t         chain_out
);

    rlt_state_t state_reg;
    rlt_state_t state_next;
    rlt_mode_t  mode_reg;
    rlt_mode_t  mode_next;
    logic       is_set_reg;
    logic       is_set_next;

    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       key_next;
    logic [OWNER_W-1:0]     owner_reg;
    logic [OWNER_W-1:0]     owner_next;
    logic                   write_reg;
    logic                   write_next;
    logic [RLT_RANGE_W-1:0] start_reg;
    logic [RLT_RANGE_W-1:0] start_next;
    logic [RLT_RANGE_W-1:0] len_reg;
    logic [RLT_RANGE_W-1:0] len_next;
    logic [RLT_RANGE_W-1:0] end_reg;
    logic [RLT_RANGE_W-1:0] end_next;
    rlt_rsp_t               result_reg;
    rlt_rsp_t               result_next;

    logic [RLT_RANGE_W:0]   end_sum;
    logic [RLT_RANGE_W-1:0] req_end;
    logic                   is_lock;

    // End of the requested range, saturated; a zero length runs to the end.
    assign end_sum = {1'b0, request.range_start} + {1'b0, request.range_len};
    assign req_end = (request.range_len == '0 || end_sum[RLT_RANGE_W]) ?
                     RLT_RANGE_MAX : end_sum[RLT_RANGE_W-1:0];
    assign is_lock = (request.lock_type == LOCK_READ) || (request.lock_type == LOCK_WRITE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (request.command == CMD_NOP) ? S_DONE : S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (chain_out.token)
                begin
                    if (mode_reg == MODE_SCAN && is_set_reg && !chain_out.found)
                    begin
                        state_next = S_LAUNCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != S_IDLE);
        done   = (state_reg == S_DONE);
        inject = (state_reg == S_LAUNCH);
    end

    always_comb
    begin
        mode_next   = mode_reg;
        is_set_next = is_set_reg;
        key_next    = key_reg;
        owner_next  = owner_reg;
        write_next  = write_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        end_next    = end_reg;
        result_next = result_reg;
        if (state_reg == S_IDLE && start)
        begin
            key_next    = request.file_key[KEY_W-1:0];
            owner_next  = request.owner_id[OWNER_W-1:0];
            write_next  = (request.lock_type == LOCK_WRITE);
            start_next  = request.range_start;
            len_next    = request.range_len;
            end_next    = req_end;
            is_set_next = 1'b0;
            result_next = '{status: STAT_OK, held_kind: HELD_NONE,
                            held_start: '0, held_len: '0};
            unique case (request.command)
                CMD_SET:
                begin
                    if (is_lock)
                    begin
                        mode_next   = MODE_SCAN;
                        is_set_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_UNLOCK;
                    end
                end
                CMD_QUERY:
                begin
                    mode_next = MODE_SCAN;
                end
                CMD_RELEASE:
                begin
                    mode_next = MODE_RELEASE;
                end
                CMD_NOP:
                begin
                    mode_next = MODE_SCAN;
                end
                default:
                begin
                    mode_next = MODE_SCAN;
                end
            endcase
        end
        else if (state_reg == S_RUN && chain_out.token)
        begin
            if (mode_reg == MODE_SCAN)
            begin
                if (is_set_reg)
                begin
                    if (chain_out.found)
                    begin
                        result_next.status = STAT_WOULD_BLOCK;
                    end
                    else
                    begin
                        mode_next = MODE_PLACE;
                    end
                end
                else if (chain_out.found)
                begin
                    result_next.held_kind  = chain_out.hit_write ? HELD_WRITE : HELD_READ;
                    result_next.held_start = chain_out.hit_start;
                    result_next.held_len   = chain_out.hit_len;
                end
            end
            else if (mode_reg == MODE_PLACE)
            begin
                result_next.status = chain_out.placed ? STAT_OK : STAT_NO_SPACE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_SCAN;
            is_set_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            is_set_reg <= is_set_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        owner_reg  <= owner_next;
        write_reg  <= write_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        end_reg    <= end_next;
        result_reg <= result_next;
    end

    assign key    = key_reg;
    assign owner  = owner_reg;
    assign bcast  = '{mode: mode_reg, req_write: write_reg, start: start_reg,
                      len: len_reg, rng_end: end_reg};
    assign result = result_reg;

    `RLT_ASSERT_IMPL(a_token_only_in_run, chain_out.token, state_reg == S_RUN)
    `RLT_ASSERT_IMPL(a_block_after_scan, done && result.status == STAT_WOULD_BLOCK,
                     mode_reg == MODE_SCAN)
    `RLT_ASSERT_IMPL(a_place_after_scan, inject && mode_reg == MODE_PLACE,
                     $past(state_reg) == S_RUN)
    `RLT_ASSERT_NEXT(a_idle_after_done, done, !busy)

endmodule

`default_nettype wire

// ----- sv/record_lock_table_top.sv -----
// Top level of the record lock table: sequencer and the chain of lock slot cells.
`default_nettype none

// Record lock table. An item is taken when start is high and busy is low; its
// result is shown on result while done is high for exactly one cycle, and the
// receiver cannot hold it off. The request is carried down the row of slot
// cells by a token that moves one cell per cycle. Query, unlock and
// release-owner take one pass over the table. A lock request takes a conflict
// pass and, when nothing blocks it, a second pass that drops the owner's
// overlapping locks and fills the lowest free slot. Command 3 changes nothing.
// No new item is taken until the result has been shown. Every slot is free
// straight after reset.
module record_lock_table_top
    import rlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = RLT_ENTRIES,
    parameter int KEY_BITS      = RLT_KEY_BITS,
    parameter int OWNER_BITS    = RLT_OWNER_BITS
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire rlt_req_t request,
    output logic          done,
    output rlt_rsp_t      result
);

    localparam int KEY_W   = (KEY_BITS < RLT_KEY_FIELD_W) ? KEY_BITS : RLT_KEY_FIELD_W;
    localparam int OWNER_W = (OWNER_BITS < RLT_OWNER_FIELD_W) ? OWNER_BITS : RLT_OWNER_FIELD_W;

    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;
    rlt_bcast_t         bcast;
    logic               inject;
    rlt_carry_t         chain [TABLE_ENTRIES+1];

    rlt_ctrl #(
        .KEY_W   (KEY_W),
        .OWNER_W (OWNER_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .key       (key),
        .owner     (owner),
        .bcast     (bcast),
        .inject    (inject),
        .chain_out (chain[TABLE_ENTRIES])
    );

    assign chain[0] = '{token: inject, found: 1'b0, placed: 1'b0, hit_write: 1'b0,
                        hit_start: '0, hit_len: '0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        rlt_cell #(
            .KEY_W   (KEY_W),
            .OWNER_W (OWNER_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key),
            .owner     (owner),
            .bcast     (bcast),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1])
        );
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the record lock table: directed and random lock traffic.
`timescale 1ns / 100ps

module tb;
    import rlt_pkg::*;

    localparam int RUN_LIMIT   = 2_000_000;
    localparam int PHASE_ITEMS = 375;

    // Expected answers of the lock table, worked out from a private copy of its slots.
    class lock_checker;
        bit                     used     [RLT_ENTRIES];
        logic [15:0]            key_of   [RLT_ENTRIES];
        logic [7:0]             owner_of [RLT_ENTRIES];
        bit                     is_write [RLT_ENTRIES];
        logic [RLT_RANGE_W-1:0] start_of [RLT_ENTRIES];
        logic [RLT_RANGE_W-1:0] len_of   [RLT_ENTRIES];
        rlt_rsp_t               pending_answers[$];
        int                     mismatches;

        function new();
            mismatches = 0;
            foreach (used[i])
                used[i] = 1'b0;
        endfunction

        // A length of zero runs to the end; any other end saturates at the top offset.
        function logic [RLT_RANGE_W-1:0] end_of(logic [RLT_RANGE_W-1:0] s,
                                                logic [RLT_RANGE_W-1:0] l);
            logic [RLT_RANGE_W:0] sum;
            if (l == '0)
                return RLT_RANGE_MAX;
            sum = {1'b0, s} + {1'b0, l};
            if (sum > {1'b0, RLT_RANGE_MAX})
                return RLT_RANGE_MAX;
            return sum[RLT_RANGE_W-1:0];
        endfunction

        function bit overlaps(int idx, rlt_req_t req);
            return start_of[idx] < end_of(req.range_start, req.range_len) &&
                   req.range_start < end_of(start_of[idx], len_of[idx]);
        endfunction

        function int first_blocker(rlt_req_t req);
            bit wants_write;
            wants_write = (req.lock_type == LOCK_WRITE);
            for (int i = 0; i < RLT_ENTRIES; i++)
            begin
                if (used[i] && owner_of[i] != req.owner_id && key_of[i] == req.file_key &&
                    overlaps(i, req) && (wants_write || is_write[i]))
                    return i;
            end
            return -1;
        endfunction

        function void drop_own(rlt_req_t req);
            for (int i = 0; i < RLT_ENTRIES; i++)
            begin
                if (used[i] && owner_of[i] == req.owner_id && key_of[i] == req.file_key &&
                    overlaps(i, req))
                    used[i] = 1'b0;
            end
        endfunction

        function rlt_rsp_t predict_answer(rlt_req_t req);
            rlt_rsp_t ans;
            int       hit;
            ans.status     = STAT_OK;
            ans.held_kind  = HELD_NONE;
            ans.held_start = '0;
            ans.held_len   = '0;
            case (req.command)
                CMD_SET:
                begin
                    if (req.lock_type != LOCK_READ && req.lock_type != LOCK_WRITE)
                        drop_own(req);
                    else if (first_blocker(req) >= 0)
                        ans.status = STAT_WOULD_BLOCK;
                    else
                    begin
                        drop_own(req);
                        ans.status = STAT_NO_SPACE;
                        for (int i = 0; i < RLT_ENTRIES; i++)
                        begin
                            if (!used[i])
                            begin
                                used[i]     = 1'b1;
                                key_of[i]   = req.file_key;
                                owner_of[i] = req.owner_id;
                                is_write[i] = (req.lock_type == LOCK_WRITE);
                                start_of[i] = req.range_start;
                                len_of[i]   = req.range_len;
                                ans.status  = STAT_OK;
                                break;
                            end
                        end
                    end
                end
                CMD_QUERY:
                begin
                    hit = first_blocker(req);
                    if (hit >= 0)
                    begin
                        ans.held_kind  = is_write[hit] ? HELD_WRITE : HELD_READ;
                        ans.held_start = start_of[hit];
                        ans.held_len   = len_of[hit];
                    end
                end
                CMD_RELEASE:
                begin
                    for (int i = 0; i < RLT_ENTRIES; i++)
                    begin
                        if (used[i] && owner_of[i] == req.owner_id)
                            used[i] = 1'b0;
                    end
                end
                default:
                    ;
            endcase
            return ans;
        endfunction

        function void note_request(rlt_req_t req);
            pending_answers.push_back(predict_answer(req));
        endfunction

        function void check_answer(rlt_rsp_t got);
            rlt_rsp_t want;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d held %0d start %0h len %0h",
                             got.status, got.held_kind, got.held_start, got.held_len);
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status || got.held_kind !== want.held_kind ||
                got.held_start !== want.held_start || got.held_len !== want.held_len)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t: expected status %0d held %0d start %0h len %0h",
                             $realtime, want.status, want.held_kind, want.held_start,
                             want.held_len);
                    $display("    got status %0d held %0d start %0h len %0h",
                             got.status, got.held_kind, got.held_start, got.held_len);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    rlt_req_t    request;
    logic        done;
    rlt_rsp_t    result;

    lock_checker book;
    int          items_sent = 0;
    int          sender_idle_pct = 0;
    int          cycle_count = 0;

    record_lock_table_top dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // A result is checked before a newly taken item is noted.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (done === 1'b1)
                book.check_answer(result);
            if (start === 1'b1 && busy === 1'b0)
                book.note_request(request);
        end
    end

    function automatic rlt_req_t make_req(logic [1:0] cmd, logic [15:0] fkey,
                                          logic [7:0] holder, logic [1:0] ltype,
                                          logic [RLT_RANGE_W-1:0] s,
                                          logic [RLT_RANGE_W-1:0] l);
        rlt_req_t r;
        r.command     = cmd;
        r.file_key    = fkey;
        r.owner_id    = holder;
        r.lock_type   = ltype;
        r.range_start = s;
        r.range_len   = l;
        return r;
    endfunction

    // Keys and owners come mostly from small pools so that locks actually meet.
    function automatic rlt_req_t random_request();
        rlt_req_t r;
        int       pick;
        case ($urandom_range(0, 4))
            0: r.file_key = 16'h0000;
            1: r.file_key = 16'h0001;
            2: r.file_key = 16'hFFFF;
            3: r.file_key = 16'h8000;
            default: r.file_key = 16'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0: r.owner_id = 8'h00;
            1: r.owner_id = 8'h01;
            2: r.owner_id = 8'h02;
            3: r.owner_id = 8'h03;
            4: r.owner_id = 8'hFF;
            default: r.owner_id = 8'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.command = CMD_SET;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                r.lock_type = LOCK_READ;
            else if (pick < 88)
                r.lock_type = LOCK_WRITE;
            else if (pick < 97)
                r.lock_type = LOCK_UNLOCK;
            else
                r.lock_type = 2'($urandom_range(3, 3));
        end
        else
        begin
            if (pick < 87)
                r.command = CMD_QUERY;
            else if (pick < 97)
                r.command = CMD_RELEASE;
            else
                r.command = CMD_NOP;
            r.lock_type = 2'($urandom_range(0, 3));
        end
        case ($urandom_range(0, 4))
            3: r.range_start = RLT_RANGE_MAX - 31'($urandom_range(0, 511));
            4: r.range_start = 31'($urandom);
            default: r.range_start = 31'($urandom_range(0, 511));
        endcase
        case ($urandom_range(0, 5))
            0: r.range_len = '0;
            4: r.range_len = 31'($urandom);
            5: r.range_len = RLT_RANGE_MAX - 31'($urandom_range(0, 15));
            default: r.range_len = 31'($urandom_range(1, 128));
        endcase
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input rlt_req_t req);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct)
            gap = $urandom_range(1, 150);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (book.pending_answers.size() != 0);
    endtask

    // One owner piles up more disjoint locks than the table holds, then another owner probes them.
    task automatic fill_table();
        logic [7:0]             holder;
        logic [15:0]            fkey;
        logic [RLT_RANGE_W-1:0] base;
        holder = 8'($urandom);
        fkey   = 16'($urandom_range(0, 1));
        base   = 31'($urandom_range(0, 4096));
        for (int i = 0; i < RLT_ENTRIES + 2; i++)
            send_item(make_req(CMD_SET, fkey, holder,
                               $urandom_range(0, 1) ? LOCK_WRITE : LOCK_READ,
                               base + 31'(i * 32), 31'd16));
        repeat (4)
            send_item(make_req(CMD_QUERY, fkey, holder + 8'd1, LOCK_WRITE,
                               base + 31'($urandom_range(0, 2200)), 31'd8));
        send_item(make_req(CMD_RELEASE, fkey, holder, LOCK_READ, '0, '0));
    endtask

    initial
    begin
        int phase_end;
        int burst_at;
        book    = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(make_req(CMD_QUERY, 16'h0000, 8'd1, LOCK_WRITE, '0, '0));
        send_item(make_req(CMD_SET, 16'h0000, 8'd1, LOCK_READ, '0, '0));
        send_item(make_req(CMD_SET, 16'h0000, 8'd2, LOCK_READ, '0, '0));
        send_item(make_req(CMD_SET, 16'h0000, 8'd3, LOCK_WRITE, 31'd100, 31'd10));
        send_item(make_req(CMD_QUERY, 16'h0000, 8'd3, LOCK_WRITE, 31'd5, 31'd1));
        send_item(make_req(CMD_QUERY, 16'h0000, 8'd3, LOCK_READ, 31'd5, 31'd1));
        // Any query type other than write only sees held write locks.
        send_item(make_req(CMD_QUERY, 16'h0000, 8'd3, LOCK_UNLOCK, 31'd5, 31'd1));
        send_item(make_req(CMD_SET, 16'h0000, 8'd1, LOCK_WRITE, 31'd10, 31'd5));
        send_item(make_req(CMD_SET, 16'h0000, 8'd2, LOCK_UNLOCK, '0, '0));
        send_item(make_req(CMD_SET, 16'h0000, 8'd1, LOCK_WRITE, 31'd10, 31'd5));
        send_item(make_req(CMD_QUERY, 16'h0000, 8'd2, LOCK_READ, 31'd14, 31'd1));
        // Lock type 3 under a set behaves as an unlock.
        send_item(make_req(CMD_SET, 16'h0000, 8'd1, 2'($urandom_range(3, 3)), 31'd12, 31'd1));
        send_item(make_req(CMD_QUERY, 16'h0000, 8'd2, LOCK_READ, 31'd14, 31'd1));
        send_item(make_req(CMD_NOP, 16'hFFFF, 8'hFF, LOCK_WRITE, RLT_RANGE_MAX, RLT_RANGE_MAX));
        send_item(make_req(CMD_SET, 16'hFFFF, 8'hFF, LOCK_WRITE, RLT_RANGE_MAX, RLT_RANGE_MAX));
        send_item(make_req(CMD_SET, 16'hFFFF, 8'h80, LOCK_WRITE, 31'h4000_0000,
                           RLT_RANGE_MAX));
        send_item(make_req(CMD_QUERY, 16'hFFFF, 8'h01, LOCK_READ, RLT_RANGE_MAX - 31'd1,
                           31'd1));
        send_item(make_req(CMD_QUERY, 16'hFFFF, 8'h80, LOCK_WRITE, '0, '0));
        send_item(make_req(CMD_RELEASE, 16'h0000, 8'hFF, LOCK_READ, '0, '0));
        send_item(make_req(CMD_RELEASE, 16'hFFFF, 8'h80, LOCK_WRITE, '0, '0));
        send_item(make_req(CMD_SET, 16'h5555, 8'h00, LOCK_READ, 31'h2AAA_AAAA, 31'h5555_5555));
        send_item(make_req(CMD_QUERY, 16'h5555, 8'h7F, LOCK_WRITE, RLT_RANGE_MAX - 31'd2,
                           '0));
        send_item(make_req(CMD_RELEASE, 16'h0000, 8'h00, LOCK_READ, '0, '0));
        send_item(make_req(CMD_RELEASE, 16'h0000, 8'h01, LOCK_READ, '0, '0));
        wait_until_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: sender_idle_pct = 67;
                3: sender_idle_pct = 31;
                default: sender_idle_pct = 0;
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            burst_at  = items_sent + $urandom_range(20, 300);
            while (items_sent < phase_end)
            begin
                if (items_sent == burst_at)
                    fill_table();
                else
                    send_item(random_request());
            end
            wait_until_drained();
        end

        repeat (2 * RLT_ENTRIES + 8) @(negedge clk);
        if (book.pending_answers.size() != 0)
            $display("%0d expected results never arrived", book.pending_answers.size());
        if (book.mismatches == 0 && book.pending_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rlt_pkg.sv
sv/rlt_cell.sv
sv/rlt_ctrl.sv
sv/record_lock_table_top.sv
tb/sv/tb.sv
